// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
// Every property is sampled on the rising clock edge and ignored while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same check as above, with a message given by the caller.
`define ASSERT_CLK_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// ===== rtl/gdd_pkg.sv =====
package gdd_pkg;

  // Field widths.
  localparam int unsigned YEAR_BITS = 16;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned DAYS_W    = 26;
  localparam int unsigned DN_W      = 26;
  localparam int unsigned MOFF_W    = 9;

  // Validation limits.
  localparam logic [HOUR_W-1:0] MAX_HOUR = 5'd23;
  localparam logic [MIN_W-1:0]  MAX_MIN  = 6'd59;
  localparam logic [DAY_W-1:0]  FEB_LEAP_LEN = 5'd29;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Division by 25 as a multiply by a reciprocal. The error term stays below
  // one twenty-fifth for dividends up to 2^14, which covers a 16-bit year shifted by two.
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP25 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned Y4_W    = YEAR_BITS - 2;
  localparam int unsigned Y16_W   = YEAR_BITS - 4;
  localparam int unsigned P100_W  = Y4_W + RECIP_W;
  localparam int unsigned P400_W  = Y16_W + RECIP_W;
  localparam int unsigned Q100_W  = P100_W - RECIP_SHIFT;
  localparam int unsigned Q400_W  = P400_W - RECIP_SHIFT;

  // Day-number constants.
  localparam logic [DN_W-1:0] DAYS_PER_YEAR = 26'd365;
  localparam logic [DN_W-1:0] DN_OFFSET     = 26'd58;

  typedef logic signed [DN_W-1:0] dnum_t;

  // Per-operand result of the date unit.
  typedef struct packed {
    logic  ok;
    dnum_t dn;
  } date_res_t;

  // Time-of-day comparison of the two operands.
  typedef struct packed {
    logic end_later;
    logic start_later;
  } tcmp_t;

  // Length of a month in a common year; zero for codes that are no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo);
    logic [DAY_W-1:0] len;
    unique case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days from 1 March to the first of the month, with January and February
  // counted at the end of the previous year.
  function automatic logic [MOFF_W-1:0] month_off(input logic [MONTH_W-1:0] mo);
    logic [MOFF_W-1:0] off;
    unique case (mo)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/gdd_date_unit.sv =====
module gdd_date_unit (
  input  logic                             clk_i,
  input  logic                             en1_i,
  input  logic                             en2_i,
  input  logic [gdd_pkg::YEAR_BITS-1:0]    year_i,
  input  logic [gdd_pkg::MONTH_W-1:0]      month_i,
  input  logic [gdd_pkg::DAY_W-1:0]        day_i,
  input  logic [gdd_pkg::HOUR_W-1:0]       hour_i,
  input  logic [gdd_pkg::MIN_W-1:0]        minute_i,
  output gdd_pkg::date_res_t               res_o
);
  import gdd_pkg::*;

  // Stage one: range checks, year shift for January and February, and the
  // reciprocal multiplies for the century terms.
  logic                  early;
  logic                  neg;
  logic [YEAR_BITS:0]    y_ext;
  logic [YEAR_BITS-1:0]  yabs;
  logic [P100_W-1:0]     p100;
  logic [P400_W-1:0]     p400;
  logic [P100_W-1:0]     p25yr;

  logic                  time_ok_q, mon_ok_q, feb_q, neg_q, corr_q;
  logic                  div4_q;
  logic [DAY_W-1:0]      day_q, mlen_q;
  logic [YEAR_BITS-1:0]  yr_q, yabs_q;
  logic [Q100_W-1:0]     q100_q, q25yr_q;
  logic [Q400_W-1:0]     q400_q;
  logic [MOFF_W-1:0]     moff_q;

  assign early = (month_i <= MONTH_FEB);
  assign y_ext = {1'b0, year_i} - (YEAR_BITS+1)'(early);
  assign neg   = (year_i == '0) && early;
  assign yabs  = neg ? '0 : y_ext[YEAR_BITS-1:0];
  assign p100  = P100_W'(yabs[YEAR_BITS-1:2]) * P100_W'(RECIP25);
  assign p400  = P400_W'(yabs[YEAR_BITS-1:4]) * P400_W'(RECIP25);
  assign p25yr = P100_W'(year_i[YEAR_BITS-1:2]) * P100_W'(RECIP25);

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      time_ok_q <= (hour_i <= MAX_HOUR) && (minute_i <= MAX_MIN);
      mon_ok_q  <= (month_i >= MONTH_JAN) && (month_i <= MONTH_DEC);
      feb_q     <= (month_i == MONTH_FEB);
      neg_q     <= neg;
      corr_q    <= (year_i == '0) && !early;
      div4_q    <= (year_i[1:0] == 2'b00);
      day_q     <= day_i;
      mlen_q    <= month_len(month_i);
      yr_q      <= year_i;
      yabs_q    <= yabs;
      q100_q    <= p100[P100_W-1:RECIP_SHIFT];
      q400_q    <= p400[P400_W-1:RECIP_SHIFT];
      q25yr_q   <= p25yr[P100_W-1:RECIP_SHIFT];
      moff_q    <= month_off(month_i);
    end
  end

  // Stage two: leap-year rule, day-of-month check and the day-number sum.
  logic             mod100;
  logic             mod400;
  logic             leap;
  logic [DAY_W-1:0] len;
  logic             ok;
  logic [DN_W-1:0]  dn;
  date_res_t        res_q;

  assign mod100 = div4_q && ((Y4_W'(q25yr_q) * Y4_W'(25)) == yr_q[YEAR_BITS-1:2]);
  assign mod400 = mod100 && (q25yr_q[1:0] == 2'b00);
  assign leap   = div4_q && !(mod100 && !mod400);
  assign len    = (feb_q && leap) ? FEB_LEAP_LEN : mlen_q;
  assign ok     = time_ok_q && mon_ok_q && (day_q != '0) && (day_q <= len);
  assign dn     = DN_W'(yabs_q) * DAYS_PER_YEAR
                + DN_W'(yabs_q[YEAR_BITS-1:2])
                - DN_W'(q100_q)
                + DN_W'(q400_q)
                + DN_W'(day_q)
                + DN_W'(moff_q)
                + DN_OFFSET
                + DN_W'(corr_q)
                - (neg_q ? DAYS_PER_YEAR : '0);

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      res_q.ok <= ok;
      res_q.dn <= dnum_t'(dn);
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/gdd_diff.sv =====
module gdd_diff (
  input  logic                          clk_i,
  input  logic                          en3_i,
  input  logic                          en4_i,
  input  gdd_pkg::date_res_t            end_res_i,
  input  gdd_pkg::date_res_t            start_res_i,
  input  gdd_pkg::tcmp_t                tcmp_i,
  output logic                          valid_res_o,
  output logic signed [gdd_pkg::DAYS_W-1:0] days_o
);
  import gdd_pkg::*;

  // Stage three: raw difference of the day numbers.
  dnum_t diff_q;
  logic  ok_q;
  tcmp_t tcmp_q;

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      diff_q <= end_res_i.dn - start_res_i.dn;
      ok_q   <= end_res_i.ok && start_res_i.ok;
      tcmp_q <= tcmp_i;
    end
  end

  // Stage four: truncate toward zero by the time of day, zero when invalid.
  logic                     pos;
  logic                     negd;
  logic signed [DAYS_W-1:0] adj;
  logic                     valid_q;
  logic signed [DAYS_W-1:0] days_q;

  assign pos  = !diff_q[DN_W-1] && (diff_q != '0);
  assign negd = diff_q[DN_W-1];

  always_comb begin
    priority if (pos && tcmp_q.start_later) begin
      adj = DAYS_W'(diff_q - dnum_t'(1));
    end else if (negd && tcmp_q.end_later) begin
      adj = DAYS_W'(diff_q + dnum_t'(1));
    end else begin
      adj = DAYS_W'(diff_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      valid_q <= ok_q;
      days_q  <= ok_q ? adj : '0;
    end
  end

  assign valid_res_o = valid_q;
  assign days_o      = days_q;

endmodule

// ===== rtl/gregorian_date_difference_days.sv =====
// Whole days elapsed between two Gregorian date-times, end minus start,
// truncated toward zero by the time of day; valid_res is low and days is
// zero when either operand fails validation. The block takes one beat per
// cycle unless a full pipeline is stalled, and delivers each result through
// four register stages (decode and divide-by-25 multiplies, day-number sum,
// subtraction, time-of-day adjustment). A stalled output holds the pipeline
// back one stage at a time, so empty stages keep accepting beats.
`include "assert_macros.svh"

module gregorian_date_difference_days (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0 up: end_year[15:0], end_month[19:16], end_day[24:20],
  // end_hour[29:25], end_minute[35:30], start_year[51:36], start_month[55:52],
  // start_day[60:56], start_hour[65:61], start_minute[71:66].
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0 up: days[25:0] (signed), zero fill [31:26].
  output logic [31:0] m_axis_tdata_o,
  // Fields from bit 0 up: valid_res[0].
  output logic [0:0]  m_axis_tuser_o
);
  import gdd_pkg::*;

  // Unpack the input beat.
  logic [YEAR_BITS-1:0] end_year, start_year;
  logic [MONTH_W-1:0]   end_month, start_month;
  logic [DAY_W-1:0]     end_day, start_day;
  logic [HOUR_W-1:0]    end_hour, start_hour;
  logic [MIN_W-1:0]     end_minute, start_minute;

  assign end_year     = s_axis_tdata_i[15:0];
  assign end_month    = s_axis_tdata_i[19:16];
  assign end_day      = s_axis_tdata_i[24:20];
  assign end_hour     = s_axis_tdata_i[29:25];
  assign end_minute   = s_axis_tdata_i[35:30];
  assign start_year   = s_axis_tdata_i[51:36];
  assign start_month  = s_axis_tdata_i[55:52];
  assign start_day    = s_axis_tdata_i[60:56];
  assign start_hour   = s_axis_tdata_i[65:61];
  assign start_minute = s_axis_tdata_i[71:66];

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Time-of-day comparison, carried alongside the date units.
  tcmp_t tcmp_d, tcmp1_q, tcmp2_q;

  assign tcmp_d.end_later   = (end_hour > start_hour) ||
                              ((end_hour == start_hour) && (end_minute > start_minute));
  assign tcmp_d.start_later = (start_hour > end_hour) ||
                              ((start_hour == end_hour) && (start_minute > end_minute));

  always_ff @(posedge clk_i) begin
    if (en1) tcmp1_q <= tcmp_d;
    if (en2) tcmp2_q <= tcmp1_q;
  end

  // One date unit per operand.
  date_res_t end_res, start_res;

  gdd_date_unit u_end (
    .clk_i    (clk_i),
    .en1_i    (en1),
    .en2_i    (en2),
    .year_i   (end_year),
    .month_i  (end_month),
    .day_i    (end_day),
    .hour_i   (end_hour),
    .minute_i (end_minute),
    .res_o    (end_res)
  );

  gdd_date_unit u_start (
    .clk_i    (clk_i),
    .en1_i    (en1),
    .en2_i    (en2),
    .year_i   (start_year),
    .month_i  (start_month),
    .day_i    (start_day),
    .hour_i   (start_hour),
    .minute_i (start_minute),
    .res_o    (start_res)
  );

  // Difference and time-of-day adjustment.
  logic                     valid_res;
  logic signed [DAYS_W-1:0] days;

  gdd_diff u_diff (
    .clk_i       (clk_i),
    .en3_i       (en3),
    .en4_i       (en4),
    .end_res_i   (end_res),
    .start_res_i (start_res),
    .tcmp_i      (tcmp2_q),
    .valid_res_o (valid_res),
    .days_o      (days)
  );

  assign s_axis_tready_o   = en1;
  assign m_axis_tvalid_o   = v4_q;
  assign m_axis_tdata_o    = {{(32-DAYS_W){1'b0}}, days};
  assign m_axis_tuser_o[0] = valid_res;

  // An invalid operand always yields zero days.
  `ASSERT_CLK(a_invalid_zero, (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (days == '0))

  // The span of a 16-bit year range never reaches the edge of the days field.
  `ASSERT_CLK_MSG(a_days_range,
    m_axis_tvalid_o |-> ((days <= 26'sd24000000) && (days >= -26'sd24000000)),
    "days out of range")

  // A full pipeline behind a stalled output refuses new beats.
  `ASSERT_CLK(a_full_stall, (v1_q && v2_q && v3_q && v4_q && !m_axis_tready_i) |-> !s_axis_tready_o)

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned YW = gdd_pkg::YEAR_BITS;
  localparam int unsigned DW = gdd_pkg::DAYS_W;
  localparam int unsigned BEATS_PER_PHASE = 185;
  localparam int unsigned FLUSH_CYCLES = 12;
  localparam longint DAYS_MAX = (longint'(1) <<< (DW - 1)) - 1;

  // One date-time operand, packed so that the year lands in the lowest bits.
  typedef struct packed {
    logic [gdd_pkg::MIN_W-1:0]   minute;
    logic [gdd_pkg::HOUR_W-1:0]  hour;
    logic [gdd_pkg::DAY_W-1:0]   day;
    logic [gdd_pkg::MONTH_W-1:0] month;
    logic [YW-1:0]               year;
  } stamp_t;

  // One result beat: validity flag and signed day count.
  typedef struct packed {
    logic                 ok;
    logic signed [DW-1:0] days;
  } span_t;

  // One row of the directed stimulus; typed rows carry their own answer.
  typedef struct {
    stamp_t later;
    stamp_t earlier;
    bit     typed;
    span_t  answer;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // Fields from bit 0 up: end operand (year, month, day, hour, minute), then start operand.
  logic [71:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // Fields from bit 0 up: days[25:0] (signed), zero fill [31:26].
  logic [31:0] m_axis_tdata_o;
  // Fields from bit 0 up: valid_res[0].
  logic [0:0]  m_axis_tuser_o;

  span_t       due_spans[$];
  row_t        plan[$];
  int unsigned fail_count;
  int unsigned idle_pct;
  int unsigned stall_pct;

  gregorian_date_difference_days dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned mo, input bit leap);
    int unsigned n;
    case (mo)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = leap ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic bit date_valid(input stamp_t t);
    int unsigned len;
    len = month_days(t.month, leap_year(t.year));
    return (t.hour <= 23) && (t.minute <= 59) && (t.day >= 1) && (t.day <= len);
  endfunction

  // Day index with 1 January of year 0 as day 0; the year starts in March.
  function automatic longint day_index(input stamp_t t);
    longint m;
    longint y;
    longint n;
    m = (longint'(t.month) + 9) % 12;
    y = longint'(t.year) - m / 10;
    n = 365 * y + longint'(t.day) - 1 + (m * 306 + 5) / 10 + y / 4 - y / 100 + y / 400 + 59;
    if (t.year == 0 && t.month >= 3) n += 1;
    return n;
  endfunction

  // Whole days from earlier to later, truncated toward zero by the time of day.
  function automatic span_t elapsed_days(input stamp_t later, input stamp_t earlier);
    span_t  r;
    longint diff;
    int     order;
    r.ok = 1'b0;
    r.days = '0;
    if (!date_valid(later) || !date_valid(earlier)) return r;
    diff = day_index(later) - day_index(earlier);
    if (later.hour != earlier.hour) order = (later.hour > earlier.hour) ? 1 : -1;
    else if (later.minute != earlier.minute) order = (later.minute > earlier.minute) ? 1 : -1;
    else order = 0;
    if (diff > 0 && order < 0) diff -= 1;
    else if (diff < 0 && order > 0) diff += 1;
    if (diff > DAYS_MAX) diff = DAYS_MAX;
    if (diff < -DAYS_MAX - 1) diff = -DAYS_MAX - 1;
    r.ok = 1'b1;
    r.days = diff[DW-1:0];
    return r;
  endfunction

  function automatic stamp_t at(input int unsigned y, input int unsigned mo,
                                input int unsigned d, input int unsigned h,
                                input int unsigned mi);
    stamp_t t;
    t.year   = YW'(y);
    t.month  = gdd_pkg::MONTH_W'(mo);
    t.day    = gdd_pkg::DAY_W'(d);
    t.hour   = gdd_pkg::HOUR_W'(h);
    t.minute = gdd_pkg::MIN_W'(mi);
    return t;
  endfunction

  // A valid date-time, with the year drawn from several regions of its range.
  function automatic stamp_t rand_stamp();
    stamp_t      t;
    int unsigned len;
    case ($urandom_range(3, 0))
      0:       t.year = YW'($urandom);
      1:       t.year = YW'($urandom_range(3, 0));
      2:       t.year = YW'($urandom_range(2100, 1880));
      default: t.year = YW'($urandom_range(65535, 65000));
    endcase
    t.month  = gdd_pkg::MONTH_W'($urandom_range(12, 1));
    len      = month_days(t.month, leap_year(t.year));
    t.day    = gdd_pkg::DAY_W'($urandom_range(len, 1));
    t.hour   = gdd_pkg::HOUR_W'($urandom_range(23, 0));
    t.minute = gdd_pkg::MIN_W'($urandom_range(59, 0));
    return t;
  endfunction

  // Breaks exactly one field of a valid date-time, or replaces it with noise.
  function automatic stamp_t spoil(input stamp_t t);
    stamp_t      r;
    int unsigned len;
    logic [63:0] raw;
    r = t;
    len = month_days(t.month, leap_year(t.year));
    raw = {$urandom, $urandom};
    case ($urandom_range(4, 0))
      0: r.hour = gdd_pkg::HOUR_W'($urandom_range(31, 24));
      1: r.minute = gdd_pkg::MIN_W'($urandom_range(63, 60));
      2: r.month = $urandom_range(1, 0) ? '0 : gdd_pkg::MONTH_W'($urandom_range(15, 13));
      3: r.day = (len == 31) ? '0 : gdd_pkg::DAY_W'($urandom_range(31, len + 1));
      default: r = raw[35:0];
    endcase
    return r;
  endfunction

  task automatic add_row(input stamp_t later, input stamp_t earlier,
                         input bit typed, input bit ok, input int days);
    row_t row;
    row.later = later;
    row.earlier = earlier;
    row.typed = typed;
    row.answer.ok = ok;
    row.answer.days = DW'(days);
    plan.push_back(row);
  endtask

  // Presents one beat from a falling edge and returns at the falling edge after it is taken.
  task automatic send_beat(input stamp_t later, input stamp_t earlier, input span_t answer);
    while ($urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {earlier, later};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    due_spans.push_back(answer);
    @(negedge clk_i);
  endtask

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Compare every result beat with the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    span_t want;
    span_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.ok = m_axis_tuser_o[0];
      got.days = m_axis_tdata_o[DW-1:0];
      if (due_spans.size() == 0) begin
        $error("result beat with no expectation pending");
        fail_count++;
      end else begin
        want = due_spans.pop_front();
        if (got.ok !== want.ok) begin
          $error("valid_res mismatch: expected %0d, actual %0d", want.ok, got.ok);
          fail_count++;
        end
        if (got.days !== want.days) begin
          $error("days mismatch: expected %0d, actual %0d", want.days, got.days);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stamp_t later;
    stamp_t earlier;
    span_t  answer;
    int unsigned pick;

    fail_count      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows: invalid fields, leap rules, year zero, time truncation, extremes.
    add_row(at(0, 0, 0, 0, 0), at(0, 0, 0, 0, 0), 1, 0, 0);
    add_row(at(65535, 15, 31, 31, 63), at(65535, 15, 31, 31, 63), 1, 0, 0);
    add_row(at(2024, 5, 10, 24, 0), at(2024, 5, 9, 0, 0), 1, 0, 0);
    add_row(at(2024, 5, 10, 0, 0), at(2024, 5, 9, 12, 60), 1, 0, 0);
    add_row(at(2024, 13, 1, 0, 0), at(2024, 1, 1, 0, 0), 1, 0, 0);
    add_row(at(2024, 1, 1, 0, 0), at(2024, 1, 0, 0, 0), 1, 0, 0);
    add_row(at(1900, 2, 29, 0, 0), at(1900, 2, 28, 0, 0), 1, 0, 0);
    add_row(at(2023, 4, 31, 0, 0), at(2023, 4, 1, 0, 0), 1, 0, 0);
    add_row(at(2000, 2, 29, 0, 0), at(2000, 2, 28, 0, 0), 1, 1, 1);
    add_row(at(0, 2, 29, 12, 0), at(0, 2, 29, 12, 0), 1, 1, 0);
    add_row(at(2024, 7, 4, 23, 59), at(2024, 7, 4, 0, 0), 1, 1, 0);
    add_row(at(2024, 7, 4, 0, 0), at(2024, 7, 4, 23, 59), 1, 1, 0);
    add_row(at(2024, 2, 29, 23, 59), at(2024, 2, 29, 23, 59), 1, 1, 0);
    add_row(at(65535, 12, 31, 23, 59), at(0, 1, 1, 0, 0), 0, 0, 0);
    add_row(at(0, 1, 1, 0, 0), at(65535, 12, 31, 23, 59), 0, 0, 0);
    add_row(at(2024, 3, 2, 10, 0), at(2024, 3, 1, 12, 0), 0, 0, 0);
    add_row(at(2024, 3, 1, 12, 0), at(2024, 3, 2, 10, 0), 0, 0, 0);
    add_row(at(0, 3, 1, 0, 0), at(0, 2, 29, 0, 0), 0, 0, 0);
    add_row(at(0, 2, 28, 5, 5), at(0, 1, 1, 5, 5), 0, 0, 0);
    add_row(at(1, 1, 1, 0, 0), at(0, 12, 31, 0, 0), 0, 0, 0);
    add_row(at(2100, 2, 28, 0, 0), at(2100, 3, 1, 0, 0), 0, 0, 0);
    add_row(at(2024, 1, 1, 0, 0), at(2024, 12, 31, 23, 59), 0, 0, 0);

    foreach (plan[i]) begin
      answer = plan[i].typed ? plan[i].answer : elapsed_days(plan[i].later, plan[i].earlier);
      send_beat(plan[i].later, plan[i].earlier, answer);
    end

    // Random phases with different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int unsigned n = 0; n < BEATS_PER_PHASE; n++) begin
        pick = $urandom_range(99, 0);
        later = rand_stamp();
        earlier = rand_stamp();
        if (pick < 40) begin
          // independent dates
        end else if (pick < 65) begin
          earlier = later;
          earlier.day = gdd_pkg::DAY_W'($urandom_range(
              month_days(later.month, leap_year(later.year)), 1));
          earlier.hour = gdd_pkg::HOUR_W'($urandom_range(23, 0));
          earlier.minute = gdd_pkg::MIN_W'($urandom_range(59, 0));
        end else if (pick < 80) begin
          earlier = later;
          earlier.hour = gdd_pkg::HOUR_W'($urandom_range(23, 0));
          earlier.minute = gdd_pkg::MIN_W'($urandom_range(59, 0));
        end else if (pick < 92) begin
          if ($urandom_range(1, 0)) later = spoil(later);
          else earlier = spoil(earlier);
        end else begin
          later = spoil(spoil(later));
          earlier = spoil(earlier);
        end
        send_beat(later, earlier, elapsed_days(later, earlier));
      end

      // After the first phase, hold off until the pipeline has fully drained.
      if (ph == 0) begin
        s_axis_tvalid_i <= 1'b0;
        while (due_spans.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (due_spans.size() != 0) @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);

    if (due_spans.size() != 0) begin
      $error("%0d expected results never arrived", due_spans.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
